// File: rtl/core/assert_macros.svh
// assert_macros.svh: assertion macros shared by the generator RTL.
// Depends on nothing; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never hold while out of reset
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("%m: assertion failed");

// ante in a cycle implies cons in the same cycle
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// ante in a cycle implies cons in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

// File: rtl/core/mrp_pkg.sv
// mrp_pkg: constants, command/status types and helpers of the generator.
// Used by mrp_ctrl, mrp_datapath and multiply_rotate_prng_core.
package mrp_pkg;

   localparam logic [63:0] WEYL_STEP  = 64'h9E3779B97F4A7C15;
   localparam logic [63:0] TAG_Z      = 64'h54454D5035583543;
   localparam logic [63:0] WEYL_START = 64'h6A09E667F3BCC908;
   localparam logic [63:0] SEED_MUL   = 64'h6A09E667F3BCC909;
   localparam logic [63:0] SEED_PI    = 64'h3243F6A8885A308D;
   localparam logic [63:0] SEED_E     = 64'hB7E151628AED2A6B;

   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned RND_W      = 5;
   localparam logic [RND_W-1:0] SCHED_INJECT_ROUNDS = 5'd16;
   localparam logic [RND_W-1:0] SCHED_LAST_ROUND    = 5'd21;

   typedef enum logic [1:0] {
      MODE_NEXT = 2'd0,
      MODE_PAIR = 2'd1,
      MODE_INIT = 2'd2,
      MODE_SEED = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KEY_0   = 3'd0,
      CSR_KEY_1   = 3'd1,
      CSR_KEY_2   = 3'd2,
      CSR_KEY_3   = 3'd3,
      CSR_NONCE_0 = 3'd4,
      CSR_NONCE_1 = 3'd5
   } csr_idx_type;

   // datapath micro-operations
   typedef enum logic [4:0] {
      OP_NONE,
      OP_SEED0, OP_SEED1, OP_SEED2, OP_KEY_CFG, OP_LOAD,
      OP_R1, OP_R2, OP_R3, OP_R4, OP_R5, OP_R6, OP_R7,
      OP_R8, OP_R9, OP_R10, OP_R11,
      OP_INJECT, OP_FINAL,
      OP_WH1, OP_WH2, OP_WH3, OP_WH4, OP_WH5
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SEED0, ST_SEED1, ST_SEED2, ST_KEY_CFG, ST_LOAD,
      ST_R1, ST_R2, ST_R3, ST_R4, ST_R5, ST_R6, ST_R7,
      ST_R8, ST_R9, ST_R10, ST_R11,
      ST_INJECT, ST_FINAL,
      ST_WH1, ST_WH2, ST_WH3, ST_WH4, ST_WH5,
      ST_RESP
   } state_type;

   typedef struct packed {
      op_type           op;
      logic [RND_W-1:0] rnd;      // schedule round index
      logic             swap;     // whiten from order b,c,d,a
      logic             capture;  // take the seed field
   } cmd_type;

   typedef struct packed {
      logic phase_even;
   } status_type;

   // rotate left by a constant-ish amount in 1..63
   function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned r);
      rotl64 = (x << r) | (x >> (64 - r));
   endfunction

endpackage

// File: rtl/core/multiply_rotate_prng_core.sv
// multiply_rotate_prng_core: top level of the keyed word generator.
// Depends on mrp_pkg, mrp_ctrl and mrp_datapath.
//
// Use: a request (req_mode, req_seed) is taken when req_valid and req_ready
// are high. Mode next gives one word on rsp_value with rsp_last set; mode
// pair gives two words, rsp_last on the second; init and seed rebuild the
// state from the key schedule and give no word. req_ready is high only
// while the core is idle: one request is worked at a time.
// A round runs states R1 to R7 on odd phases and R1 to R11 on even ones,
// the shared 32x32 multiplier serving R2 to R5; whitening then runs WH1 to
// WH5 before a word is shown, and a pair's second word is whitened anew
// once the first is taken. Init takes 22 rounds plus 16 injections, the
// key register load, the state load and the feedforward; seed runs the key
// derivation states SEED0 to SEED2 in place of the register load.
// A stalled receiver holds the word on rsp_value; the core waits until it
// is taken. Key and nonce registers are written through csr_*, always
// ready. Synchronous reset clears state words, round phase and registers.
module multiply_rotate_prng_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_mode,
   input  logic [63:0]                    req_seed,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [63:0]                    rsp_value,
   output logic                           rsp_last,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [mrp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [63:0]                    csr_data
);
   import mrp_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   mrp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_last  (rsp_last),
      .cmd       (cmd),
      .status    (status)
   );

   mrp_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .seed      (req_seed),
      .csr_we    (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .value     (rsp_value)
   );

endmodule

// File: rtl/core/mrp_datapath.sv
// mrp_datapath: state words, key registers, shared 32x32 multiplier.
// Depends on mrp_pkg; driven by commands from mrp_ctrl.
module mrp_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  mrp_pkg::cmd_type                  cmd,
   output mrp_pkg::status_type               status,
   input  logic [63:0]                       seed,
   input  logic                              csr_we,
   input  logic [mrp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [63:0]                       csr_data,
   output logic [63:0]                       value
);
   import mrp_pkg::*;

   logic [63:0] a_ff, b_ff, c_ff, d_ff, a_in, b_in, c_in, d_in;
   logic [1:0]  ph_ff, ph_in;
   logic [63:0] key_ff [4];
   logic [63:0] nonce_ff [2];
   logic [63:0] kw_ff [4];
   logic [63:0] kw_in [4];
   logic [63:0] nw0_ff, nw1_ff, nw0_in, nw1_in;
   logic [63:0] seed_ff, weyl_ff, weyl_in, acc_ff, acc_in, t_ff, t_in, res_ff, res_in;
   logic [31:0] mul_x, mul_y;
   logic [63:0] prod, sx, wn, nc, hi, lo, tw, ts, p, q, r, s;

   // key rotation of the first eight schedule rounds
   function automatic logic [63:0] krot(input logic [63:0] k, input logic [RND_W-1:0] i);
      case (i[2:0])
         3'd1:    krot = rotl64(k, 2);
         3'd3:    krot = rotl64(k, 4);
         3'd5:    krot = rotl64(k, 6);
         3'd7:    krot = rotl64(k, 8);
         default: krot = k;
      endcase
   endfunction

   assign sx    = rotl64(seed_ff, 17);
   assign weyl_in = weyl_ff + WEYL_STEP;
   assign status.phase_even = ~ph_ff[0];
   assign value = res_ff;

   // operand selection of the shared multiplier
   always_comb begin
      mul_x = '0;
      mul_y = '0;
      case (cmd.op)
         OP_R2, OP_R5: begin mul_x = b_ff[63:32]; mul_y = c_ff[31:0]; end
         OP_R3:        begin mul_x = c_ff[63:32]; mul_y = d_ff[31:0]; end
         OP_R4:        begin mul_x = a_ff[31:0];  mul_y = b_ff[63:32]; end
         OP_WH2:       begin mul_x = t_ff[63:32]; mul_y = t_ff[63:32]; end
         OP_WH3:       begin mul_x = t_ff[63:32]; mul_y = t_ff[31:0]; end
         OP_WH4:       begin mul_x = t_ff[31:0];  mul_y = t_ff[31:0]; end
         OP_SEED0:     begin mul_x = sx[31:0];    mul_y = SEED_MUL[31:0]; end
         OP_SEED1:     begin mul_x = sx[63:32];   mul_y = SEED_MUL[31:0]; end
         OP_SEED2:     begin mul_x = sx[31:0];    mul_y = SEED_MUL[63:32]; end
         default:      begin mul_x = '0;          mul_y = '0; end
      endcase
      // R5 reads c and d
      if (cmd.op == OP_R5) begin
         mul_x = c_ff[63:32];
         mul_y = d_ff[31:0];
      end
   end

   assign prod = {32'd0, mul_x} * {32'd0, mul_y};

   // schedule nonce word
   always_comb begin
      hi = cmd.rnd[0] ? nw1_ff : nw0_ff;
      lo = cmd.rnd[0] ? nw0_ff : nw1_ff;
      nc = {hi[31:0], lo[31:0]};
   end

   // whitening front end
   always_comb begin
      p  = cmd.swap ? b_ff : a_ff;
      q  = cmd.swap ? c_ff : b_ff;
      r  = cmd.swap ? d_ff : c_ff;
      s  = cmd.swap ? a_ff : d_ff;
      tw = p ^ rotl64(q, 32) ^ r ^ rotl64(s, 16);
      tw = tw ^ rotl64(tw, 27);
      ts = t_ff + acc_ff;
      ts = ts ^ (rotl64(ts, 31) & rotl64(ts, 53));
      ts = ts ^ (ts >> 32);
   end

   // next values per micro-operation
   always_comb begin
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff;
      ph_in = ph_ff;
      kw_in = kw_ff;
      nw0_in = nw0_ff; nw1_in = nw1_ff;
      acc_in = acc_ff; t_in = t_ff; res_in = res_ff;
      case (cmd.op)
         OP_SEED0: begin
            kw_in[0] = seed_ff + WEYL_STEP;
            kw_in[2] = seed_ff ^ SEED_PI;
            kw_in[3] = rotl64(seed_ff, 32) + SEED_E;
            nw0_in   = '0;
            nw1_in   = '0;
            acc_in   = prod;
         end
         OP_SEED1: acc_in = acc_ff + {prod[31:0], 32'd0};
         OP_SEED2: kw_in[1] = acc_ff + {prod[31:0], 32'd0};
         OP_KEY_CFG: begin
            kw_in  = key_ff;
            nw0_in = nonce_ff[0];
            nw1_in = nonce_ff[1];
         end
         OP_LOAD: begin
            a_in  = kw_ff[0];
            b_in  = kw_ff[1] ^ nw0_ff;
            c_in  = kw_ff[2] ^ nw1_ff;
            d_in  = kw_ff[3] ^ TAG_Z;
            ph_in = 2'd0;
         end
         OP_R1: begin
            a_in = a_ff + rotl64(b_ff, 7);
            b_in = b_ff + rotl64(c_ff, 11);
            c_in = c_ff + rotl64(d_ff, 13);
            d_in = d_ff + rotl64(a_ff, 17);
         end
         OP_R2, OP_R5: a_in = a_ff + {32'd0, prod[31:0]};
         OP_R3: b_in = b_ff + {32'd0, prod[31:0]};
         OP_R4: c_in = c_ff + {32'd0, prod[31:0]};
         OP_R6: begin
            a_in = a_ff ^ (rotl64(b_ff, 19) + c_ff);
            b_in = b_ff ^ (rotl64(c_ff, 23) + d_ff);
         end
         OP_R7: begin
            c_in = c_ff ^ (rotl64(d_ff, 7) + a_ff);
            d_in = d_ff ^ (rotl64(a_ff, 11) + b_ff);
            if (ph_ff[0]) ph_in = ph_ff + 2'd1;
         end
         OP_R8:  d_in = d_ff ^ ((ph_ff[1] ? rotl64(b_ff, 15) : rotl64(b_ff, 19)) + a_ff);
         OP_R9:  c_in = c_ff ^ ((ph_ff[1] ? rotl64(a_ff, 19) : rotl64(a_ff, 23)) + d_ff);
         OP_R10: b_in = b_ff ^ ((ph_ff[1] ? rotl64(d_ff, 11) : rotl64(d_ff, 7)) + c_ff);
         OP_R11: begin
            a_in  = a_ff ^ ((ph_ff[1] ? rotl64(c_ff, 15) : rotl64(c_ff, 11)) + b_ff);
            ph_in = ph_ff + 2'd1;
         end
         OP_INJECT: begin
            if (cmd.rnd < 5'd8) begin
               a_in = a_ff ^ krot(kw_ff[0], cmd.rnd) ^ weyl_in;
               b_in = b_ff ^ krot(kw_ff[1], cmd.rnd) ^ (weyl_in << 17);
               c_in = c_ff ^ krot(kw_ff[2], cmd.rnd) ^ (weyl_in >> 13);
               d_in = d_ff ^ krot(kw_ff[3], cmd.rnd) ^ rotl64(weyl_in, 31);
            end else begin
               a_in = a_ff ^ nc;
               b_in = b_ff ^ rotl64(nc, 19) ^ {{(64-RND_W){1'b0}}, cmd.rnd};
               d_in = d_ff ^ rotl64(nc, 43);
            end
         end
         OP_FINAL: begin
            a_in = a_ff ^ kw_ff[0];
            b_in = b_ff ^ kw_ff[1];
            c_in = c_ff ^ kw_ff[2];
            d_in = d_ff ^ kw_ff[3];
         end
         OP_WH1: t_in = tw;
         OP_WH2: acc_in = {prod[31:0], 32'd0};
         OP_WH3: acc_in = acc_ff + {prod[62:0], 1'b0};
         OP_WH4: acc_in = acc_ff + {32'd0, prod[63:32]};
         OP_WH5: res_in = ts;
         default: ;
      endcase
   end

   // state words and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= '0; b_ff <= '0; c_ff <= '0; d_ff <= '0;
         ph_ff <= '0;
         key_ff   <= '{default: '0};
         nonce_ff <= '{default: '0};
      end else begin
         a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in;
         ph_ff <= ph_in;
         if (csr_we) begin
            case (csr_index)
               CSR_KEY_0:   key_ff[0]   <= csr_data;
               CSR_KEY_1:   key_ff[1]   <= csr_data;
               CSR_KEY_2:   key_ff[2]   <= csr_data;
               CSR_KEY_3:   key_ff[3]   <= csr_data;
               CSR_NONCE_0: nonce_ff[0] <= csr_data;
               CSR_NONCE_1: nonce_ff[1] <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // working payload registers
   always_ff @(posedge clock) begin
      kw_ff  <= kw_in;
      nw0_ff <= nw0_in;
      nw1_ff <= nw1_in;
      acc_ff <= acc_in;
      t_ff   <= t_in;
      res_ff <= res_in;
      if (cmd.capture) seed_ff <= seed;
      if (cmd.op == OP_LOAD) weyl_ff <= WEYL_START;
      else if (cmd.op == OP_INJECT) weyl_ff <= weyl_in;
   end

endmodule

// File: rtl/core/mrp_ctrl.sv
// mrp_ctrl: sequencer for rounds, key schedule, whitening and handshakes.
// Depends on mrp_pkg and assert_macros.svh; commands mrp_datapath.
`include "assert_macros.svh"
module mrp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_mode,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_last,
   output mrp_pkg::cmd_type      cmd,
   input  mrp_pkg::status_type   status
);
   import mrp_pkg::*;

   state_type        state_ff, state_in;
   logic [RND_W-1:0] cnt_ff, cnt_in;
   logic             sched_ff, sched_in, pair_ff, pair_in, second_ff, second_in;
   logic             req_fire, round_end;

   assign req_fire = req_valid & req_ready;

   // next state
   always_comb begin
      state_in  = state_ff;
      round_end = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (mode_type'(req_mode))
                  MODE_INIT: state_in = ST_KEY_CFG;
                  MODE_SEED: state_in = ST_SEED0;
                  default:   state_in = ST_R1;
               endcase
            end
         end
         ST_SEED0:   state_in = ST_SEED1;
         ST_SEED1:   state_in = ST_SEED2;
         ST_SEED2:   state_in = ST_LOAD;
         ST_KEY_CFG: state_in = ST_LOAD;
         ST_LOAD:    state_in = ST_R1;
         ST_R1:      state_in = ST_R2;
         ST_R2:      state_in = ST_R3;
         ST_R3:      state_in = ST_R4;
         ST_R4:      state_in = ST_R5;
         ST_R5:      state_in = ST_R6;
         ST_R6:      state_in = ST_R7;
         ST_R7: begin
            if (status.phase_even) state_in = ST_R8;
            else round_end = 1'b1;
         end
         ST_R8:      state_in = ST_R9;
         ST_R9:      state_in = ST_R10;
         ST_R10:     state_in = ST_R11;
         ST_R11:     round_end = 1'b1;
         ST_INJECT:  state_in = ST_R1;
         ST_FINAL:   state_in = ST_IDLE;
         ST_WH1:     state_in = ST_WH2;
         ST_WH2:     state_in = ST_WH3;
         ST_WH3:     state_in = ST_WH4;
         ST_WH4:     state_in = ST_WH5;
         ST_WH5:     state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_ready) state_in = (pair_ff && !second_ff) ? ST_WH1 : ST_IDLE;
         end
         default:    state_in = ST_IDLE;
      endcase
      // where a finished round goes
      if (round_end) begin
         if (!sched_ff) state_in = ST_WH1;
         else if (cnt_ff < SCHED_INJECT_ROUNDS) state_in = ST_INJECT;
         else if (cnt_ff == SCHED_LAST_ROUND) state_in = ST_FINAL;
         else state_in = ST_R1;
      end
   end

   // counters and request flags
   always_comb begin
      cnt_in    = cnt_ff;
      sched_in  = sched_ff;
      pair_in   = pair_ff;
      second_in = second_ff;
      if (req_fire) begin
         sched_in  = (req_mode == MODE_INIT) || (req_mode == MODE_SEED);
         pair_in   = (req_mode == MODE_PAIR);
         second_in = 1'b0;
      end
      if (state_ff == ST_LOAD) cnt_in = '0;
      if (state_ff == ST_INJECT) cnt_in = cnt_ff + 5'd1;
      if (round_end && sched_ff && cnt_ff >= SCHED_INJECT_ROUNDS
          && cnt_ff != SCHED_LAST_ROUND) cnt_in = cnt_ff + 5'd1;
      if (state_ff == ST_RESP && rsp_ready) second_in = 1'b1;
   end

   // outputs
   always_comb begin
      cmd.rnd     = cnt_ff;
      cmd.swap    = second_ff;
      cmd.capture = req_fire;
      req_ready   = (state_ff == ST_IDLE);
      rsp_valid   = (state_ff == ST_RESP);
      rsp_last    = !pair_ff || second_ff;
      case (state_ff)
         ST_SEED0:   cmd.op = OP_SEED0;
         ST_SEED1:   cmd.op = OP_SEED1;
         ST_SEED2:   cmd.op = OP_SEED2;
         ST_KEY_CFG: cmd.op = OP_KEY_CFG;
         ST_LOAD:    cmd.op = OP_LOAD;
         ST_R1:      cmd.op = OP_R1;
         ST_R2:      cmd.op = OP_R2;
         ST_R3:      cmd.op = OP_R3;
         ST_R4:      cmd.op = OP_R4;
         ST_R5:      cmd.op = OP_R5;
         ST_R6:      cmd.op = OP_R6;
         ST_R7:      cmd.op = OP_R7;
         ST_R8:      cmd.op = OP_R8;
         ST_R9:      cmd.op = OP_R9;
         ST_R10:     cmd.op = OP_R10;
         ST_R11:     cmd.op = OP_R11;
         ST_INJECT:  cmd.op = OP_INJECT;
         ST_FINAL:   cmd.op = OP_FINAL;
         ST_WH1:     cmd.op = OP_WH1;
         ST_WH2:     cmd.op = OP_WH2;
         ST_WH3:     cmd.op = OP_WH3;
         ST_WH4:     cmd.op = OP_WH4;
         ST_WH5:     cmd.op = OP_WH5;
         default:    cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         sched_ff  <= 1'b0;
         pair_ff   <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         sched_ff  <= sched_in;
         pair_ff   <= pair_in;
         second_ff <= second_in;
      end
   end

   `ASSERT_NEVER(a_cnt_range, clock, reset, cnt_ff > SCHED_LAST_ROUND)
   `ASSERT_NEVER(a_no_overlap, clock, reset, req_ready && rsp_valid)
   `ASSERT_NEXT(a_final_idle, clock, reset, state_ff == ST_FINAL, state_ff == ST_IDLE)
   `ASSERT_IMPL(a_resp_sched, clock, reset, rsp_valid, !sched_ff)

endmodule

// File: bench/multiply_rotate_prng_core_tb.sv
// multiply_rotate_prng_core_tb: self-checking bench for the keyed word generator.
// Depends on mrp_pkg and multiply_rotate_prng_core; predicts every word in-bench
// and checks each response field by field.
module multiply_rotate_prng_core_tb;
   import mrp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] LOW32 = 64'hFFFFFFFF;
   localparam int unsigned IDLE_LIMIT = 5000;
   localparam int unsigned INIT_SETTLE = 400;

   typedef struct packed {
      logic [63:0] value;
      logic        last;
   } word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_mode = MODE_NEXT;
   logic [63:0] req_seed = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [63:0] rsp_value;
   logic rsp_last;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_KEY_0;
   logic [63:0] csr_data = '0;

   // model state
   logic [63:0] key_reg [6];
   logic [63:0] st_a, st_b, st_c, st_d;
   logic [1:0]  phase;
   word_type    expected_words [$];

   int unsigned errors = 0;
   int unsigned idle_count = 0;
   int unsigned stall_left = 0;
   bit          quiet = 1'b0;
   bit          sink_quiet = 1'b0;

   multiply_rotate_prng_core u_dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [63:0] rot(input logic [63:0] x, input int unsigned r);
      r = r % 64;
      return (r == 0) ? x : ((x << r) | (x >> (64 - r)));
   endfunction

   function automatic logic [63:0] cross_hl(input logic [63:0] x, input logic [63:0] y);
      return ((x >> 32) * (y & LOW32)) & LOW32;
   endfunction

   function automatic logic [63:0] cross_lh(input logic [63:0] x, input logic [63:0] y);
      return ((x & LOW32) * (y >> 32)) & LOW32;
   endfunction

   // one mixing round on the model state
   task automatic mix_round();
      logic [63:0] a, b, c, d, a0;
      int unsigned ph;
      a = st_a; b = st_b; c = st_c; d = st_d; a0 = a;
      ph = phase;
      a += rot(b, 7); b += rot(c, 11); c += rot(d, 13); d += rot(a0, 17);
      a += cross_hl(b, c); b += cross_hl(c, d); c += cross_lh(a, b); a += cross_hl(c, d);
      a ^= rot(b, 19) + c; b ^= rot(c, 23) + d;
      c ^= rot(d, 7) + a;  d ^= rot(a, 11) + b;
      if (ph % 2 == 0) begin
         d ^= rot(b, 19 - ph * 2) + a;
         c ^= rot(a, 23 - ph * 2) + d;
         b ^= rot(d, 7 + ph * 2) + c;
         a ^= rot(c, 11 + ph * 2) + b;
      end
      st_a = a; st_b = b; st_c = c; st_d = d;
      phase = phase + 2'd1;
   endtask

   function automatic logic [63:0] whitened(input logic [63:0] p, input logic [63:0] q,
                                            input logic [63:0] r, input logic [63:0] s);
      logic [63:0] t;
      logic [127:0] sq;
      t = p ^ rot(q, 32) ^ r ^ rot(s, 16);
      t ^= rot(t, 27);
      sq = {64'd0, t} * {64'd0, t};
      t += sq[95:32];
      t ^= rot(t, 31) & rot(t, 53);
      t ^= t >> 32;
      return t;
   endfunction

   // 22-round key schedule with key feedforward
   task automatic key_schedule(input logic [63:0] k0, input logic [63:0] k1,
                               input logic [63:0] k2, input logic [63:0] k3,
                               input logic [63:0] n0, input logic [63:0] n1);
      logic [63:0] weyl, hi, lo, nc;
      int unsigned r;
      weyl = WEYL_START;
      st_a = k0; st_b = k1 ^ n0; st_c = k2 ^ n1; st_d = k3 ^ TAG_Z;
      phase = 2'd0;
      for (int i = 0; i < 16; i++) begin
         mix_round();
         weyl += WEYL_STEP;
         if (i < 8) begin
            r = (i % 2) ? i + 1 : 0;
            st_a ^= rot(k0, r) ^ weyl;
            st_b ^= rot(k1, r) ^ (weyl << 17);
            st_c ^= rot(k2, r) ^ (weyl >> 13);
            st_d ^= rot(k3, r) ^ rot(weyl, 31);
         end else begin
            hi = (i % 2) ? n1 : n0;
            lo = (i % 2) ? n0 : n1;
            nc = {hi[31:0], lo[31:0]};
            st_a ^= nc;
            st_b ^= rot(nc, 19) ^ 64'(i);
            st_d ^= rot(nc, 43);
         end
      end
      for (int i = 0; i < 6; i++) mix_round();
      st_a ^= k0; st_b ^= k1; st_c ^= k2; st_d ^= k3;
   endtask

   // work out the words a request causes
   task automatic predict_request(input logic [1:0] mode, input logic [63:0] seed);
      case (mode)
         MODE_NEXT: begin
            mix_round();
            expected_words.push_back('{whitened(st_a, st_b, st_c, st_d), 1'b1});
         end
         MODE_PAIR: begin
            mix_round();
            expected_words.push_back('{whitened(st_a, st_b, st_c, st_d), 1'b0});
            expected_words.push_back('{whitened(st_b, st_c, st_d, st_a), 1'b1});
         end
         MODE_INIT: key_schedule(key_reg[0], key_reg[1], key_reg[2], key_reg[3],
                                 key_reg[4], key_reg[5]);
         default: key_schedule(seed + WEYL_STEP, rot(seed, 17) * SEED_MUL,
                               seed ^ SEED_PI, rot(seed, 32) + SEED_E, 64'd0, 64'd0);
      endcase
   endtask

   // valid stays high after acceptance until the next request or a drain
   task automatic send_request(input logic [1:0] mode, input logic [63:0] seed);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= mode;
      req_seed  <= seed;
      do @(posedge clock); while (!(req_valid && req_ready));
      predict_request(mode, seed);
   endtask

   // wait for all words, then a settle gap so init/seed work finishes
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (INIT_SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input logic [63:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      key_reg[idx] = data;
   endtask

   task automatic write_all_keys(input logic [63:0] v0, input logic [63:0] v1,
                                 input logic [63:0] v2, input logic [63:0] v3,
                                 input logic [63:0] v4, input logic [63:0] v5);
      write_reg(CSR_KEY_0, v0);
      write_reg(CSR_KEY_1, v1);
      write_reg(CSR_KEY_2, v2);
      write_reg(CSR_KEY_3, v3);
      write_reg(CSR_NONCE_0, v4);
      write_reg(CSR_NONCE_1, v5);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // directed: every mode, field extremes, ignored seed, schedule phase
   task automatic test_directed();
      send_request(MODE_NEXT, 64'd0);
      send_request(MODE_NEXT, '1);
      send_request(MODE_PAIR, 64'h5555_5555_5555_5555);
      send_request(MODE_PAIR, '1);
      send_request(MODE_INIT, '1);
      send_request(MODE_NEXT, 64'd0);
      send_request(MODE_PAIR, 64'hAAAA_AAAA_AAAA_AAAA);
      send_request(MODE_SEED, 64'd0);
      send_request(MODE_NEXT, 64'd0);
      send_request(MODE_SEED, '1);
      send_request(MODE_PAIR, 64'd0);
      send_request(MODE_NEXT, 64'd0);
      send_request(MODE_SEED, 64'h8000_0000_0000_0001);
      send_request(MODE_PAIR, 64'd0);
      send_request(MODE_PAIR, 64'd0);
      send_request(MODE_NEXT, 64'd0);
      send_request(MODE_NEXT, 64'd0);
      drain();
   endtask

   // key registers at extremes and mixed bit patterns, each followed by init
   task automatic test_key_settings();
      write_all_keys('1, '1, '1, '1, '1, '1);
      send_request(MODE_INIT, rand64());
      send_request(MODE_PAIR, rand64());
      send_request(MODE_NEXT, rand64());
      drain();
      write_all_keys(64'd1, 64'h8000_0000_0000_0000, 64'd0, '1,
                     64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF);
      send_request(MODE_INIT, 64'd0);
      send_request(MODE_NEXT, 64'd0);
      send_request(MODE_PAIR, 64'd0);
      drain();
   endtask

   // random mix, mostly stream words with occasional reseeding
   task automatic test_random(input int unsigned count);
      int unsigned pick;
      for (int unsigned n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) send_request(MODE_NEXT, rand64());
         else if (pick < 90) send_request(MODE_PAIR, rand64());
         else if (pick < 95) send_request(MODE_INIT, rand64());
         else send_request(MODE_SEED, rand64());
      end
      drain();
   endtask

   // response sink and checker
   always @(posedge clock) begin
      word_type exp_word;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $error("unexpected word value=%h last=%b", rsp_value, rsp_last);
               errors++;
            end else begin
               exp_word = expected_words.pop_front();
               if (rsp_value !== exp_word.value) begin
                  $error("value: expected %h, got %h", exp_word.value, rsp_value);
                  errors++;
               end
               if (rsp_last !== exp_word.last) begin
                  $error("last: expected %b, got %b", exp_word.last, rsp_last);
                  errors++;
               end
            end
         end
         // random stall bursts on the receiving side
         if (sink_quiet) rsp_ready <= 1'b1;
         else if (stall_left != 0) begin
            stall_left--;
            if (stall_left == 0) rsp_ready <= 1'b1;
         end else if (rsp_ready && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            stall_left = $urandom_range(1, 7);
         end else rsp_ready <= 1'b1;
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)
          || reset)
         idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (idle_count >= IDLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < 6; i++) key_reg[i] = '0;
      st_a = '0; st_b = '0; st_c = '0; st_d = '0;
      phase = 2'd0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_key_settings();
      write_all_keys(rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
      test_random(420);
      write_all_keys(64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0);
      test_random(200);
      write_all_keys(rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
      quiet = 1'b1;
      sink_quiet = 1'b1;
      test_random(250);
      if (errors == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule

// File: multiply_rotate_prng_core.f
+incdir+rtl/core
rtl/core/mrp_pkg.sv
rtl/core/mrp_datapath.sv
rtl/core/mrp_ctrl.sv
rtl/core/multiply_rotate_prng_core.sv
bench/multiply_rotate_prng_core_tb.sv
